// ----- hw/rtl/vicp_pkg.sv -----
// Shared types and constants for the vector interface command processor.
`timescale 1ns / 1ps
`default_nettype none

package vicp_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned REM_W      = 10;
  localparam int unsigned SEL_W      = 4;
  localparam int unsigned MEM_ADDR_W = 12;
  localparam int unsigned PROG_W     = 19;
  localparam int unsigned IMM_W      = 16;
  localparam int unsigned APB_ADDR_W = 3;

  // command codes (low 7 bits of the command byte)
  localparam logic [6:0] CMD_NOP    = 7'h00;
  localparam logic [6:0] CMD_STCYCL = 7'h01;
  localparam logic [6:0] CMD_ITOP   = 7'h04;
  localparam logic [6:0] CMD_STMOD  = 7'h05;
  localparam logic [6:0] CMD_MARK   = 7'h07;
  localparam logic [6:0] CMD_FLUSHE = 7'h10;
  localparam logic [6:0] CMD_MSCAL  = 7'h14;
  localparam logic [6:0] CMD_MSCALF = 7'h15;
  localparam logic [6:0] CMD_MSCNT  = 7'h17;
  localparam logic [6:0] CMD_STMASK = 7'h20;
  localparam logic [6:0] CMD_STROW  = 7'h30;
  localparam logic [6:0] CMD_STCOL  = 7'h31;
  localparam logic [6:0] CMD_MPG    = 7'h4A;

  // holes in the unpack code range
  localparam logic [6:0] CMD_NOUNPK0 = 7'h67;
  localparam logic [6:0] CMD_NOUNPK1 = 7'h77;
  localparam logic [6:0] CMD_NOUNPK2 = 7'h7B;

  localparam logic [REM_W-1:0] REM_STMASK   = 10'd1;
  localparam logic [REM_W-1:0] REM_ROWCOL   = 10'd4;
  localparam logic [REM_W-1:0] REM_MPG_FULL = 10'd512;

  // register selects
  localparam logic [SEL_W-1:0] SEL_CYCLE = 4'd0;
  localparam logic [SEL_W-1:0] SEL_ITOP  = 4'd1;
  localparam logic [SEL_W-1:0] SEL_MODE  = 4'd2;
  localparam logic [SEL_W-1:0] SEL_MARK  = 4'd3;
  localparam logic [SEL_W-1:0] SEL_MASK  = 4'd4;
  localparam logic [SEL_W-1:0] SEL_ROW0  = 4'd5;
  localparam logic [SEL_W-1:0] SEL_COL0  = 4'd9;

  // configuration register index (word index, paddr[2])
  localparam logic [0:0] REG_MASK_INVALID = 1'b0;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_REG_WRITE  = 4'd1,
    EV_MEM_WRITE  = 4'd2,
    EV_START_PROG = 4'd3,
    EV_CONT_PROG  = 4'd4,
    EV_FLUSH      = 4'd5,
    EV_INVALID    = 4'd6,
    EV_MARK       = 4'd7,
    EV_UNPACK     = 4'd8
  } event_e;

  // classified word as it travels from front to back
  typedef struct packed {
    event_e                kind;
    logic [SEL_W-1:0]      sel;
    logic [WORD_W-1:0]     value;
    logic [MEM_ADDR_W-1:0] addr;
    logic                  overflow;
    logic                  irq;
    logic                  busy;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vicp_front.sv -----
// Front end: accepts stream words, tracks command/payload state, classifies each word.
`timescale 1ns / 1ps
`default_nettype none

module vicp_front import vicp_pkg::*; #(
  parameter int unsigned MICRO_MEM_BYTES = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              mask_invalid_i,
  input  wire logic              in_valid_i,
  input  wire logic [WORD_W-1:0] data_word_i,
  output logic                   in_stall_o,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output op_t                    op_o
);

  // micro memory size must be a power of two; the front end does not check it
  localparam int unsigned AW = $clog2(MICRO_MEM_BYTES);

  logic [6:0]       cmd_q, cmd_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic             wrap_q, wrap_d;
  logic             accept;

  logic [AW:0]            addr_inc;
  logic [AW+MEM_ADDR_W-1:0] addr_ext;
  logic [PROG_W-1:0]      imm_x8;
  logic [6:0]             code;
  logic [7:0]             num;
  logic [IMM_W-1:0]       imm;
  logic [1:0]             idx;
  logic                   is_unpack;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept;

  assign code     = data_word_i[30:24];
  assign num      = data_word_i[23:16];
  assign imm      = data_word_i[15:0];
  assign imm_x8   = {imm, 3'b000};
  assign addr_inc = {1'b0, addr_q} + (AW+1)'(4);
  assign addr_ext = {{MEM_ADDR_W{1'b0}}, addr_q};
  assign idx      = 2'b00 - rem_q[1:0];
  assign is_unpack = (code[6:5] == 2'b11) && (code != CMD_NOUNPK0) &&
                     (code != CMD_NOUNPK1) && (code != CMD_NOUNPK2);

  always_comb begin
    cmd_d  = cmd_q;
    rem_d  = rem_q;
    addr_d = addr_q;
    wrap_d = wrap_q;
    op_o   = '0;
    op_o.kind = EV_NONE;
    if (rem_q != '0) begin
      case (cmd_q)
        CMD_STMASK: begin
          op_o.kind  = EV_REG_WRITE;
          op_o.sel   = SEL_MASK;
          op_o.value = data_word_i;
        end
        CMD_STROW: begin
          op_o.kind  = EV_REG_WRITE;
          op_o.sel   = SEL_ROW0 + {2'b00, idx};
          op_o.value = data_word_i;
        end
        CMD_STCOL: begin
          op_o.kind  = EV_REG_WRITE;
          op_o.sel   = SEL_COL0 + {2'b00, idx};
          op_o.value = data_word_i;
        end
        default: begin
          op_o.kind     = EV_MEM_WRITE;
          op_o.addr     = addr_ext[MEM_ADDR_W-1:0];
          op_o.value    = data_word_i;
          op_o.overflow = wrap_q;
          addr_d        = addr_inc[AW-1:0];
          if (addr_inc[AW]) begin
            wrap_d = 1'b1;
          end
        end
      endcase
      rem_d = rem_q - REM_W'(1);
      if (rem_d == '0) begin
        cmd_d = CMD_NOP;
      end
    end else begin
      case (code)
        CMD_NOP: ;
        CMD_STCYCL: begin
          op_o.kind  = EV_REG_WRITE;
          op_o.sel   = SEL_CYCLE;
          op_o.value = {16'h0000, imm};
        end
        CMD_ITOP: begin
          op_o.kind  = EV_REG_WRITE;
          op_o.sel   = SEL_ITOP;
          op_o.value = {22'h0, imm[9:0]};
        end
        CMD_STMOD: begin
          op_o.kind  = EV_REG_WRITE;
          op_o.sel   = SEL_MODE;
          op_o.value = {30'h0, imm[1:0]};
        end
        CMD_MARK: begin
          op_o.kind  = EV_MARK;
          op_o.sel   = SEL_MARK;
          op_o.value = {16'h0000, imm};
        end
        CMD_FLUSHE: op_o.kind = EV_FLUSH;
        CMD_MSCAL, CMD_MSCALF: begin
          op_o.kind  = EV_START_PROG;
          op_o.value = {16'h0000, imm};
        end
        CMD_MSCNT: op_o.kind = EV_CONT_PROG;
        CMD_STMASK: begin
          cmd_d = code;
          rem_d = REM_STMASK;
        end
        CMD_STROW, CMD_STCOL: begin
          cmd_d = code;
          rem_d = REM_ROWCOL;
        end
        CMD_MPG: begin
          cmd_d  = code;
          rem_d  = (num == 8'd0) ? REM_MPG_FULL : {1'b0, num, 1'b0};
          addr_d = imm_x8[AW-1:0];
          wrap_d = 1'b0;
        end
        default: begin
          if (is_unpack) begin
            op_o.kind = EV_UNPACK;
          end else begin
            op_o.kind = EV_INVALID;
            op_o.irq  = !mask_invalid_i;
          end
        end
      endcase
    end
    op_o.busy = (rem_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= CMD_NOP;
      rem_q  <= '0;
      addr_q <= '0;
      wrap_q <= 1'b0;
    end else if (accept) begin
      cmd_q  <= cmd_d;
      rem_q  <= rem_d;
      addr_q <= addr_d;
      wrap_q <= wrap_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vicp_queue.sv -----
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module vicp_queue import vicp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  input  wire logic pop_i,
  output op_t       op_o,
  output q_status_t status_o
);

  op_t        entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign op_o           = entry_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vicp_back.sv -----
// Back end: output register that turns classified words into result transfers.
`timescale 1ns / 1ps
`default_nettype none

module vicp_back import vicp_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire q_status_t               q_status_i,
  input  wire op_t                     op_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [3:0]                   event_kind_o,
  output logic [SEL_W-1:0]             register_select_o,
  output logic [WORD_W-1:0]            register_value_o,
  output logic [MEM_ADDR_W-1:0]        memory_byte_address_o,
  output logic [WORD_W-1:0]            memory_data_o,
  output logic [PROG_W-1:0]            program_address_o,
  output logic                         overflow_flag_o,
  output logic                         interrupt_pulse_o,
  output logic                         busy_res_o
);

  op_t  res_q;
  logic valid_q, valid_d;
  logic is_reg, is_mem, is_start;

  assign pop_o = !q_status_i.empty && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= op_i;
    end
  end

  assign is_reg   = (res_q.kind == EV_REG_WRITE) || (res_q.kind == EV_MARK);
  assign is_mem   = (res_q.kind == EV_MEM_WRITE);
  assign is_start = (res_q.kind == EV_START_PROG);

  assign out_valid_o           = valid_q;
  assign event_kind_o          = res_q.kind;
  assign register_select_o     = is_reg ? res_q.sel : '0;
  assign register_value_o      = is_reg ? res_q.value : '0;
  assign memory_byte_address_o = is_mem ? res_q.addr : '0;
  assign memory_data_o         = is_mem ? res_q.value : '0;
  assign program_address_o     = is_start ? {res_q.value[IMM_W-1:0], 3'b000} : '0;
  assign overflow_flag_o       = is_mem && res_q.overflow;
  assign interrupt_pulse_o     = (res_q.kind == EV_INVALID) && res_q.irq;
  assign busy_res_o            = res_q.busy;

endmodule

`default_nettype wire

// ----- hw/rtl/vector_interface_command_processor.sv -----
// Vector interface command processor top level: APB register, front end, queue, back end.
//
// Usage: one 32-bit stream word per input transfer on data_word_i (in_valid_i /
// in_stall_o). While no payload is pending the word is a command (code in bits
// 30:24, count in 23:16, immediate in 15:0); STMASK, STROW, STCOL and MPG then
// take 1, 4, 4 or 2*count payload words (512 for MPG with count 0). Every input
// word yields exactly one result transfer on the output channel (out_valid_o / out_stall_i).
// Throughput: one word per cycle while in_stall_o is low and the receiver takes each result,
// set by the combinational decode in the front end and the output register in the back
// end. The queue is written at the input transfer and the output register when the
// back end pops the entry, which an output stall can hold off; out_valid_o rises with it.
// The two-entry queue decouples the sides; in_stall_o rises only when it is
// full, which can be the cycle after the receiver first stalls with words arriving.
// Reset clears the command state, the queue, the output valid and
// mask_invalid_error; the block comes out idle and expects a command word.
// mask_invalid_error sits at APB byte address 0; it is to be written while idle, which the block does not enforce.
// MICRO_MEM_BYTES must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module vector_interface_command_processor import vicp_pkg::*; #(
  parameter int unsigned MICRO_MEM_BYTES = 4096
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [WORD_W-1:0]       pwdata,
  output logic [WORD_W-1:0]            prdata,
  output logic                         pready,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [WORD_W-1:0]       data_word_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [3:0]                   event_kind_o,
  output logic [SEL_W-1:0]             register_select_o,
  output logic [WORD_W-1:0]            register_value_o,
  output logic [MEM_ADDR_W-1:0]        memory_byte_address_o,
  output logic [WORD_W-1:0]            memory_data_o,
  output logic [PROG_W-1:0]            program_address_o,
  output logic                         overflow_flag_o,
  output logic                         interrupt_pulse_o,
  output logic                         busy_res_o
);

  logic      mask_inv_q;
  logic      cfg_wr;
  logic      push;
  logic      pop;
  op_t       front_op;
  op_t       head_op;
  q_status_t q_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2:2] == REG_MASK_INVALID);
  assign prdata = (paddr[2:2] == REG_MASK_INVALID) ? {31'h0, mask_inv_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_inv_q <= 1'b0;
    end else if (cfg_wr) begin
      mask_inv_q <= pwdata[0];
    end
  end

  vicp_front #(
    .MICRO_MEM_BYTES(MICRO_MEM_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mask_invalid_i(mask_inv_q),
    .in_valid_i    (in_valid_i),
    .data_word_i   (data_word_i),
    .in_stall_o    (in_stall_o),
    .q_full_i      (q_status.full),
    .push_o        (push),
    .op_o          (front_op)
  );

  vicp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (front_op),
    .pop_i   (pop),
    .op_o    (head_op),
    .status_o(q_status)
  );

  vicp_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_status_i           (q_status),
    .op_i                 (head_op),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .event_kind_o         (event_kind_o),
    .register_select_o    (register_select_o),
    .register_value_o     (register_value_o),
    .memory_byte_address_o(memory_byte_address_o),
    .memory_data_o        (memory_data_o),
    .program_address_o    (program_address_o),
    .overflow_flag_o      (overflow_flag_o),
    .interrupt_pulse_o    (interrupt_pulse_o),
    .busy_res_o           (busy_res_o)
  );

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  a_irq_only_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && interrupt_pulse_o |-> event_kind_o == EV_INVALID)
    else $error("interrupt on a non-invalid result");

  a_ovf_only_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_flag_o |-> event_kind_o == EV_MEM_WRITE)
    else $error("overflow flag outside a micro memory write");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && q_status.full |-> pop)
    else $error("queue written while full");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the vector interface command processor.
`timescale 1ns / 1ps

module tb import vicp_pkg::*; ();

  localparam int MEM_BYTES = 4096;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    event_e                kind;
    logic [SEL_W-1:0]      sel;
    logic [WORD_W-1:0]     value;
    logic [MEM_ADDR_W-1:0] addr;
    logic [WORD_W-1:0]     mdata;
    logic [PROG_W-1:0]     prog;
    logic                  ovf;
    logic                  irq;
    logic                  busy;
  } cmd_result_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    bit                typed;
    cmd_result_t       res;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [WORD_W-1:0]     pwdata = '0;
  logic [WORD_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [WORD_W-1:0]     data_word_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [3:0]            event_kind_o;
  logic [SEL_W-1:0]      register_select_o;
  logic [WORD_W-1:0]     register_value_o;
  logic [MEM_ADDR_W-1:0] memory_byte_address_o;
  logic [WORD_W-1:0]     memory_data_o;
  logic [PROG_W-1:0]     program_address_o;
  logic                  overflow_flag_o;
  logic                  interrupt_pulse_o;
  logic                  busy_res_o;

  wire in_xfer  = in_valid_i && !in_stall_o;
  wire out_xfer = out_valid_o && !out_stall_i;

  vector_interface_command_processor #(
    .MICRO_MEM_BYTES(MEM_BYTES)
  ) dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .data_word_i          (data_word_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .event_kind_o         (event_kind_o),
    .register_select_o    (register_select_o),
    .register_value_o     (register_value_o),
    .memory_byte_address_o(memory_byte_address_o),
    .memory_data_o        (memory_data_o),
    .program_address_o    (program_address_o),
    .overflow_flag_o      (overflow_flag_o),
    .interrupt_pulse_o    (interrupt_pulse_o),
    .busy_res_o           (busy_res_o)
  );

  always #10 clk_i = ~clk_i;

  // command decoder state mirrored on the testbench side
  logic [6:0]       cmd_pending = CMD_NOP;
  logic [REM_W-1:0] words_left = '0;
  int               wr_addr = 0;
  bit               addr_wrapped = 1'b0;
  logic             mask_invalid = 1'b0;

  cmd_result_t expected_results[$];
  stim_row_t   directed_rows[$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          stall_run = 0;

  function automatic cmd_result_t decode_stream_word(input logic [WORD_W-1:0] w);
    cmd_result_t r;
    logic [6:0]  code;
    logic [7:0]  num;
    logic [15:0] imm;
    logic [1:0]  idx;
    r = '0;
    code = w[30:24];
    num = w[23:16];
    imm = w[15:0];
    if (words_left != 0) begin
      idx = 2'(3'd4 - words_left[2:0]);
      if (cmd_pending == CMD_STMASK) begin
        r.kind = EV_REG_WRITE;
        r.sel = SEL_MASK;
        r.value = w;
      end else if (cmd_pending == CMD_STROW) begin
        r.kind = EV_REG_WRITE;
        r.sel = SEL_ROW0 + SEL_W'(idx);
        r.value = w;
      end else if (cmd_pending == CMD_STCOL) begin
        r.kind = EV_REG_WRITE;
        r.sel = SEL_COL0 + SEL_W'(idx);
        r.value = w;
      end else begin
        r.kind = EV_MEM_WRITE;
        r.addr = MEM_ADDR_W'(wr_addr);
        r.mdata = w;
        r.ovf = addr_wrapped;
        wr_addr = wr_addr + 4;
        if (wr_addr >= MEM_BYTES) begin
          wr_addr = wr_addr % MEM_BYTES;
          addr_wrapped = 1'b1;
        end
      end
      words_left = words_left - REM_W'(1);
      if (words_left == 0) cmd_pending = CMD_NOP;
    end else begin
      case (code)
        CMD_NOP: begin
        end
        CMD_STCYCL: begin
          r.kind = EV_REG_WRITE;
          r.sel = SEL_CYCLE;
          r.value = WORD_W'(imm);
        end
        CMD_ITOP: begin
          r.kind = EV_REG_WRITE;
          r.sel = SEL_ITOP;
          r.value = WORD_W'(imm[9:0]);
        end
        CMD_STMOD: begin
          r.kind = EV_REG_WRITE;
          r.sel = SEL_MODE;
          r.value = WORD_W'(imm[1:0]);
        end
        CMD_MARK: begin
          r.kind = EV_MARK;
          r.sel = SEL_MARK;
          r.value = WORD_W'(imm);
        end
        CMD_FLUSHE: r.kind = EV_FLUSH;
        CMD_MSCAL, CMD_MSCALF: begin
          r.kind = EV_START_PROG;
          r.prog = {imm, 3'b000};
        end
        CMD_MSCNT: r.kind = EV_CONT_PROG;
        CMD_STMASK: begin
          cmd_pending = code;
          words_left = REM_STMASK;
        end
        CMD_STROW, CMD_STCOL: begin
          cmd_pending = code;
          words_left = REM_ROWCOL;
        end
        CMD_MPG: begin
          cmd_pending = code;
          words_left = (num == 0) ? REM_MPG_FULL : {1'b0, num, 1'b0};
          wr_addr = (int'(imm) * 8) % MEM_BYTES;
          addr_wrapped = 1'b0;
        end
        default: begin
          if (code >= 7'h60 && code != CMD_NOUNPK0 && code != CMD_NOUNPK1 &&
              code != CMD_NOUNPK2) begin
            r.kind = EV_UNPACK;
          end else begin
            r.kind = EV_INVALID;
            r.irq = !mask_invalid;
          end
        end
      endcase
    end
    r.busy = (words_left != 0);
    return r;
  endfunction

  function automatic string show_result(input cmd_result_t r);
    return $sformatf("kind=%0d sel=%0d val=%h addr=%h data=%h prog=%h ovf=%b irq=%b busy=%b",
                     r.kind, r.sel, r.value, r.addr, r.mdata, r.prog, r.ovf, r.irq, r.busy);
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic cmd_result_t mk(input event_e k, input logic [SEL_W-1:0] sel,
                                     input logic [WORD_W-1:0] v, input logic [PROG_W-1:0] prog,
                                     input logic irq, input logic busy);
    cmd_result_t r;
    r = '0;
    r.kind = k;
    r.sel = sel;
    r.value = v;
    r.prog = prog;
    r.irq = irq;
    r.busy = busy;
    return r;
  endfunction

  function automatic void add_row(input logic [WORD_W-1:0] w, input bit typed,
                                  input cmd_result_t r);
    stim_row_t s;
    s.word = w;
    s.typed = typed;
    s.res = r;
    directed_rows.push_back(s);
  endfunction

  function automatic logic [WORD_W-1:0] cmd_word(input logic [6:0] code, input logic [7:0] num,
                                                 input logic [15:0] imm);
    return {1'($urandom_range(0, 1)), code, num, imm};
  endfunction

  function automatic logic [WORD_W-1:0] payload_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] w, input bit typed, input cmd_result_t fixed);
    cmd_result_t p;
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = decode_stream_word(w);
    expected_results.push_back(typed ? fixed : p);
    words_sent++;
  endtask

  task automatic send_sequence();
    int          pick;
    int          n;
    logic [15:0] imm;
    logic [6:0]  code;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      n = $urandom_range(1, 4);
      imm = 16'($urandom);
      if ($urandom_range(0, 3) == 0) imm[8:0] = 9'h1FF - 9'($urandom_range(0, 3));
      send_word(cmd_word(CMD_MPG, 8'(n), imm), 1'b0, '0);
      repeat (2 * n) send_word(payload_word(), 1'b0, '0);
    end else if (pick < 45) begin
      code = $urandom_range(0, 1) ? CMD_STROW : CMD_STCOL;
      send_word(cmd_word(code, 8'($urandom), 16'($urandom)), 1'b0, '0);
      repeat (4) send_word(payload_word(), 1'b0, '0);
    end else if (pick < 53) begin
      send_word(cmd_word(CMD_STMASK, 8'($urandom), 16'($urandom)), 1'b0, '0);
      send_word(payload_word(), 1'b0, '0);
    end else if (pick < 85) begin
      case ($urandom_range(0, 8))
        0: code = CMD_NOP;
        1: code = CMD_STCYCL;
        2: code = CMD_ITOP;
        3: code = CMD_STMOD;
        4: code = CMD_MARK;
        5: code = CMD_FLUSHE;
        6: code = CMD_MSCAL;
        7: code = CMD_MSCALF;
        default: code = CMD_MSCNT;
      endcase
      send_word(cmd_word(code, 8'($urandom), 16'($urandom)), 1'b0, '0);
    end else begin
      send_word($urandom, 1'b0, '0);
    end
  endtask

  task automatic run_random(input int budget);
    int stop;
    stop = words_sent + budget;
    while (words_sent < stop) send_sequence();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mask_invalid(input logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MASK_INVALID, 2'b00};
    pwdata <= WORD_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    mask_invalid = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== WORD_W'(v))
      report_mismatch($sformatf("mask_invalid_error read exp %h got %h", WORD_W'(v), prdata));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: free-running, random, and long stall runs, switched every so often
  always @(posedge clk_i) begin : receiver
    logic s;
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 120);
      stall_mode = $urandom_range(0, 2);
    end
    mode_left--;
    case (stall_mode)
      0: s = 1'b0;
      1: s = ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run == 0 && $urandom_range(0, 7) == 0) stall_run = $urandom_range(2, 8);
        s = (stall_run != 0);
        if (stall_run != 0) stall_run--;
      end
    endcase
    out_stall_i <= s;
  end

  always @(posedge clk_i) begin : result_check
    cmd_result_t got;
    cmd_result_t want;
    if (rst_ni && out_xfer) begin
      got.kind = event_e'(event_kind_o);
      got.sel = register_select_o;
      got.value = register_value_o;
      got.addr = memory_byte_address_o;
      got.mdata = memory_data_o;
      got.prog = program_address_o;
      got.ovf = overflow_flag_o;
      got.irq = interrupt_pulse_o;
      got.busy = busy_res_o;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer: %s", show_result(got)));
      end else begin
        want = expected_results.pop_front();
        if (got !== want)
          report_mismatch($sformatf("\n  exp %s\n  got %s", show_result(want), show_result(got)));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || in_xfer || out_xfer || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] imm;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mask_invalid(1'b0);

    add_row(32'h0000_0000, 1'b1, mk(EV_NONE, '0, '0, '0, 1'b0, 1'b0));
    add_row(32'h01FF_FFFF, 1'b1, mk(EV_REG_WRITE, SEL_CYCLE, 32'hFFFF, '0, 1'b0, 1'b0));
    add_row(32'h04AA_FFFF, 1'b1, mk(EV_REG_WRITE, SEL_ITOP, 32'h3FF, '0, 1'b0, 1'b0));
    add_row(32'h0500_FFFF, 1'b1, mk(EV_REG_WRITE, SEL_MODE, 32'h3, '0, 1'b0, 1'b0));
    add_row(32'h8700_1234, 1'b1, mk(EV_MARK, SEL_MARK, 32'h1234, '0, 1'b0, 1'b0));
    add_row(32'h10FF_FFFF, 1'b1, mk(EV_FLUSH, '0, '0, '0, 1'b0, 1'b0));
    add_row(32'h1400_FFFF, 1'b1, mk(EV_START_PROG, '0, '0, 19'h7FFF8, 1'b0, 1'b0));
    add_row(32'h9500_0001, 1'b0, '0);
    add_row(32'h1700_0000, 1'b1, mk(EV_CONT_PROG, '0, '0, '0, 1'b0, 1'b0));
    add_row(32'h0200_0000, 1'b1, mk(EV_INVALID, '0, '0, '0, 1'b1, 1'b0));
    add_row(32'hE700_0000, 1'b1, mk(EV_INVALID, '0, '0, '0, 1'b1, 1'b0));
    add_row(32'h6000_0000, 1'b1, mk(EV_UNPACK, '0, '0, '0, 1'b0, 1'b0));
    add_row(32'hFFFF_FFFF, 1'b1, mk(EV_UNPACK, '0, '0, '0, 1'b0, 1'b0));
    add_row(32'h2000_0000, 1'b1, mk(EV_NONE, '0, '0, '0, 1'b0, 1'b1));
    add_row(32'hFFFF_FFFF, 1'b1, mk(EV_REG_WRITE, SEL_MASK, 32'hFFFF_FFFF, '0, 1'b0, 1'b0));
    add_row(32'h3000_0000, 1'b1, mk(EV_NONE, '0, '0, '0, 1'b0, 1'b1));
    add_row(32'h0000_0000, 1'b0, '0);
    add_row(32'h1234_5678, 1'b0, '0);
    add_row(32'h8000_0001, 1'b0, '0);
    add_row(32'hFFFF_FFFF, 1'b0, '0);
    // program load at the top of micro memory, wraps on the third word
    add_row(32'h4A02_FFFF, 1'b1, mk(EV_NONE, '0, '0, '0, 1'b0, 1'b1));
    add_row(32'hFFFF_FFFF, 1'b0, '0);
    add_row(32'h0000_0000, 1'b0, '0);
    add_row(32'hA5A5_5A5A, 1'b0, '0);
    add_row(32'h5A5A_A5A5, 1'b0, '0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);
    drain();

    write_mask_invalid(1'b1);
    run_random(60);
    drain();

    write_mask_invalid(1'b0);
    run_random(60);
    drain();

    // full-size program load (count 0), then more random traffic
    write_mask_invalid(1'b1);
    imm = 16'($urandom);
    send_word(cmd_word(CMD_MPG, 8'd0, imm), 1'b0, '0);
    repeat (2 * 256) send_word(payload_word(), 1'b0, '0);
    run_random(50);
    drain();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/vicp_pkg.sv
hw/rtl/vicp_front.sv
hw/rtl/vicp_queue.sv
hw/rtl/vicp_back.sv
hw/rtl/vector_interface_command_processor.sv
tb/tb.sv
